// File: hw/rtl/sbot_pkg.sv
package sbot_pkg;

	localparam int COORD_WIDTH = 32;
	localparam int FRAC_WIDTH = 17;
	localparam int FRAC_SHIFT = FRAC_WIDTH - 1;
	localparam int CFG_DATA_WIDTH = (COORD_WIDTH > FRAC_WIDTH) ? COORD_WIDTH : FRAC_WIDTH;
	localparam int CFG_INDEX_WIDTH = 3;

	// widths of the doubled quantities; m and d in units of 2^-32, the extent in 2^-16
	localparam int EXT_W = COORD_WIDTH + 1;
	localparam int D_W = COORD_WIDTH + FRAC_WIDTH;
	localparam int A_W = D_W;
	localparam int M_W = COORD_WIDTH + FRAC_SHIFT + 3;
	localparam int AX_W = M_W + 1;
	localparam int MD_W = M_W + D_W;
	localparam int EA_W = EXT_W + A_W + 1;
	localparam int DIFF_W = MD_W + 1;
	localparam int RHS_W = EA_W + 1 + FRAC_SHIFT;
	localparam int CMP_W = DIFF_W + 1;

	// operand splits for the cross products
	localparam int M_LO_W = M_W / 2;
	localparam int M_HI_W = M_W - M_LO_W;
	localparam int D_LO_W = D_W / 2;
	localparam int D_HI_W = D_W - D_LO_W;
	localparam int A_LO_W = A_W / 2;
	localparam int A_HI_W = A_W - A_LO_W;
	localparam int HH_W = M_HI_W + D_HI_W;
	localparam int HL_W = M_HI_W + D_LO_W + 1;
	localparam int LH_W = M_LO_W + 1 + D_HI_W;
	localparam int LL_W = M_LO_W + D_LO_W;
	localparam int EAH_W = EXT_W + A_HI_W + 1;
	localparam int EAL_W = EXT_W + A_LO_W + 1;

	typedef logic signed [COORD_WIDTH-1:0] coord_t;
	typedef logic [FRAC_WIDTH-1:0] frac_t;
	typedef logic [CFG_DATA_WIDTH-1:0] cfg_data_t;
	typedef logic signed [EXT_W-1:0] ext_t;
	typedef logic signed [D_W-1:0] d_t;
	typedef logic [A_W-1:0] a_t;
	typedef logic signed [M_W-1:0] m_t;
	typedef logic signed [MD_W-1:0] md_t;
	typedef logic signed [EA_W-1:0] ea_t;
	typedef logic signed [DIFF_W-1:0] diff_t;
	typedef logic signed [RHS_W-1:0] rhs_t;

	localparam frac_t FRAC_ONE = frac_t'(1) << FRAC_SHIFT;
	localparam a_t EPS = a_t'(1) << FRAC_SHIFT;

	typedef enum logic [CFG_INDEX_WIDTH-1:0] {
		REG_START_X = 3'd0,
		REG_START_Y = 3'd1,
		REG_START_Z = 3'd2,
		REG_DIR_X = 3'd3,
		REG_DIR_Y = 3'd4,
		REG_DIR_Z = 3'd5,
		REG_FRACTION = 3'd6
	} cfg_reg_t;

	typedef struct packed {
		coord_t start_x;
		coord_t start_y;
		coord_t start_z;
		coord_t dir_x;
		coord_t dir_y;
		coord_t dir_z;
		frac_t frac;
	} seg_cfg_t;

	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
		logic s4;
		logic s5;
		logic s6;
	} stage_en_t;

	typedef struct packed {
		logic signed [HH_W-1:0] hh;
		logic signed [HL_W-1:0] hl;
		logic signed [LH_W-1:0] lh;
		logic [LL_W-1:0] ll;
	} md_part_t;

	typedef struct packed {
		logic signed [EAH_W-1:0] hi;
		logic signed [EAL_W-1:0] lo;
	} ea_part_t;

	function automatic md_part_t md_split(m_t m, d_t d);
		md_part_t r;
		r.hh = $signed(m[M_W-1:M_LO_W]) * $signed(d[D_W-1:D_LO_W]);
		r.hl = $signed(m[M_W-1:M_LO_W]) * $signed({1'b0, d[D_LO_W-1:0]});
		r.lh = $signed({1'b0, m[M_LO_W-1:0]}) * $signed(d[D_W-1:D_LO_W]);
		r.ll = m[M_LO_W-1:0] * d[D_LO_W-1:0];
		return r;
	endfunction

	function automatic md_t md_join(md_part_t p);
		return (MD_W'(p.hh) <<< (M_LO_W + D_LO_W)) + (MD_W'(p.hl) <<< M_LO_W)
			+ (MD_W'(p.lh) <<< D_LO_W) + MD_W'(p.ll);
	endfunction

	function automatic ea_part_t ea_split(ext_t e, a_t a);
		ea_part_t r;
		r.hi = e * $signed({1'b0, a[A_W-1:A_LO_W]});
		r.lo = e * $signed({1'b0, a[A_LO_W-1:0]});
		return r;
	endfunction

	function automatic ea_t ea_join(ea_part_t p);
		return (EA_W'(p.hi) <<< A_LO_W) + EA_W'(p.lo);
	endfunction

endpackage

// File: hw/rtl/sbot_if.sv
interface sbot_box_if;
	logic valid;
	logic ready;
	sbot_pkg::coord_t box_min_x;
	sbot_pkg::coord_t box_min_y;
	sbot_pkg::coord_t box_min_z;
	sbot_pkg::coord_t box_max_x;
	sbot_pkg::coord_t box_max_y;
	sbot_pkg::coord_t box_max_z;

	modport source (
		output valid, box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z,
		input ready
	);
	modport sink (
		input valid, box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z,
		output ready
	);
endinterface

interface sbot_result_if;
	logic valid;
	logic ready;
	logic overlaps;

	modport source (output valid, overlaps, input ready);
	modport sink (input valid, overlaps, output ready);
endinterface

interface sbot_cfg_if;
	logic valid;
	logic ready;
	logic [sbot_pkg::CFG_INDEX_WIDTH-1:0] index;
	sbot_pkg::cfg_data_t data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// File: hw/rtl/sbot_cfg.sv
module sbot_cfg (
	input logic clk,
	input logic arst_n,
	sbot_cfg_if.sink cfg,
	output sbot_pkg::seg_cfg_t seg
);

	sbot_pkg::seg_cfg_t seg_q;

	assign cfg.ready = 1'b1;
	assign seg = seg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seg_q.start_x <= '0;
			seg_q.start_y <= '0;
			seg_q.start_z <= '0;
			seg_q.dir_x <= '0;
			seg_q.dir_y <= '0;
			seg_q.dir_z <= '0;
			seg_q.frac <= sbot_pkg::FRAC_ONE;
		end else if (cfg.valid && cfg.ready) begin
			unique case (sbot_pkg::cfg_reg_t'(cfg.index))
				sbot_pkg::REG_START_X: seg_q.start_x <= cfg.data[sbot_pkg::COORD_WIDTH-1:0];
				sbot_pkg::REG_START_Y: seg_q.start_y <= cfg.data[sbot_pkg::COORD_WIDTH-1:0];
				sbot_pkg::REG_START_Z: seg_q.start_z <= cfg.data[sbot_pkg::COORD_WIDTH-1:0];
				sbot_pkg::REG_DIR_X: seg_q.dir_x <= cfg.data[sbot_pkg::COORD_WIDTH-1:0];
				sbot_pkg::REG_DIR_Y: seg_q.dir_y <= cfg.data[sbot_pkg::COORD_WIDTH-1:0];
				sbot_pkg::REG_DIR_Z: seg_q.dir_z <= cfg.data[sbot_pkg::COORD_WIDTH-1:0];
				sbot_pkg::REG_FRACTION: seg_q.frac <= cfg.data[sbot_pkg::FRAC_WIDTH-1:0];
				default: begin
				end
			endcase
		end
	end

endmodule

// File: hw/rtl/sbot_front.sv
module sbot_front (
	input logic clk,
	input sbot_pkg::stage_en_t en,
	input sbot_pkg::seg_cfg_t seg,
	input sbot_pkg::coord_t lo [3],
	input sbot_pkg::coord_t hi [3],
	output sbot_pkg::m_t m_s2 [3],
	output sbot_pkg::d_t d_s2 [3],
	output sbot_pkg::ext_t ext_s2 [3],
	output sbot_pkg::a_t absd_s2 [3]
);

	localparam int OFF_W = sbot_pkg::COORD_WIDTH + 2;

	sbot_pkg::coord_t start [3];
	sbot_pkg::coord_t dir [3];
	sbot_pkg::ext_t ext_s1 [3];
	sbot_pkg::ext_t ctr_s1 [3];
	sbot_pkg::d_t d_s1 [3];
	logic signed [OFF_W-1:0] off [3];

	assign start[0] = seg.start_x;
	assign start[1] = seg.start_y;
	assign start[2] = seg.start_z;
	assign dir[0] = seg.dir_x;
	assign dir[1] = seg.dir_y;
	assign dir[2] = seg.dir_z;

	// stage 1: extent, corner sum, scaled direction
	always_ff @(posedge clk) begin
		if (en.s1) begin
			for (int i = 0; i < 3; i++) begin
				ext_s1[i] <= sbot_pkg::EXT_W'(hi[i]) - sbot_pkg::EXT_W'(lo[i]);
				ctr_s1[i] <= sbot_pkg::EXT_W'(lo[i]) + sbot_pkg::EXT_W'(hi[i]);
				d_s1[i] <= sbot_pkg::D_W'(dir[i] * $signed({1'b0, seg.frac}));
			end
		end
	end

	// 2*start - (min + max), still in Q16.16
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			off[i] = OFF_W'($signed({start[i], 1'b0})) - OFF_W'(ctr_s1[i]);
		end
	end

	// stage 2: m = 2p + d - (min + max) and |d|, everything in Q.32
	always_ff @(posedge clk) begin
		if (en.s2) begin
			for (int i = 0; i < 3; i++) begin
				m_s2[i] <= (sbot_pkg::M_W'(off[i]) <<< sbot_pkg::FRAC_SHIFT)
					+ sbot_pkg::M_W'(d_s1[i]);
				d_s2[i] <= d_s1[i];
				ext_s2[i] <= ext_s1[i];
				absd_s2[i] <= d_s1[i][sbot_pkg::D_W-1] ? sbot_pkg::A_W'(-d_s1[i])
					: sbot_pkg::A_W'(d_s1[i]);
			end
		end
	end

endmodule

// File: hw/rtl/sbot_cross.sv
module sbot_cross (
	input logic clk,
	input sbot_pkg::stage_en_t en,
	input sbot_pkg::m_t m_s2 [3],
	input sbot_pkg::d_t d_s2 [3],
	input sbot_pkg::ext_t ext_s2 [3],
	input sbot_pkg::a_t absd_s2 [3],
	output sbot_pkg::diff_t diff_s5 [3],
	output sbot_pkg::rhs_t rhs_s5 [3],
	output logic sep_s5
);

	localparam int NEXT1 [3] = '{1, 2, 0};
	localparam int NEXT2 [3] = '{2, 0, 1};

	logic [sbot_pkg::M_W-1:0] absm [3];
	logic signed [sbot_pkg::AX_W-1:0] ax_rhs [3];
	sbot_pkg::a_t a [3];
	logic axis_sep;

	sbot_pkg::md_part_t mda_s3 [3];
	sbot_pkg::md_part_t mdb_s3 [3];
	sbot_pkg::ea_part_t eaa_s3 [3];
	sbot_pkg::ea_part_t eab_s3 [3];
	logic sep_s3;

	sbot_pkg::md_t mda_s4 [3];
	sbot_pkg::md_t mdb_s4 [3];
	sbot_pkg::ea_t eaa_s4 [3];
	sbot_pkg::ea_t eab_s4 [3];
	logic sep_s4;

	// coordinate axis tests: |m| > e + |d|
	always_comb begin
		axis_sep = 1'b0;
		for (int i = 0; i < 3; i++) begin
			absm[i] = m_s2[i][sbot_pkg::M_W-1] ? sbot_pkg::M_W'(-m_s2[i])
				: sbot_pkg::M_W'(m_s2[i]);
			ax_rhs[i] = (sbot_pkg::AX_W'(ext_s2[i]) <<< sbot_pkg::FRAC_SHIFT)
				+ sbot_pkg::AX_W'(absd_s2[i]);
			a[i] = absd_s2[i] + sbot_pkg::EPS;
			axis_sep = axis_sep || ($signed({1'b0, absm[i]}) > ax_rhs[i]);
		end
	end

	// stage 3: partial products of the cross terms
	always_ff @(posedge clk) begin
		if (en.s3) begin
			sep_s3 <= axis_sep;
			for (int i = 0; i < 3; i++) begin
				mda_s3[i] <= sbot_pkg::md_split(m_s2[NEXT1[i]], d_s2[NEXT2[i]]);
				mdb_s3[i] <= sbot_pkg::md_split(m_s2[NEXT2[i]], d_s2[NEXT1[i]]);
				eaa_s3[i] <= sbot_pkg::ea_split(ext_s2[NEXT1[i]], a[NEXT2[i]]);
				eab_s3[i] <= sbot_pkg::ea_split(ext_s2[NEXT2[i]], a[NEXT1[i]]);
			end
		end
	end

	// stage 4: full products
	always_ff @(posedge clk) begin
		if (en.s4) begin
			sep_s4 <= sep_s3;
			for (int i = 0; i < 3; i++) begin
				mda_s4[i] <= sbot_pkg::md_join(mda_s3[i]);
				mdb_s4[i] <= sbot_pkg::md_join(mdb_s3[i]);
				eaa_s4[i] <= sbot_pkg::ea_join(eaa_s3[i]);
				eab_s4[i] <= sbot_pkg::ea_join(eab_s3[i]);
			end
		end
	end

	// stage 5: cross difference and bound, extent carries an implicit 2^16
	always_ff @(posedge clk) begin
		if (en.s5) begin
			sep_s5 <= sep_s4;
			for (int i = 0; i < 3; i++) begin
				diff_s5[i] <= sbot_pkg::DIFF_W'(mda_s4[i]) - sbot_pkg::DIFF_W'(mdb_s4[i]);
				rhs_s5[i] <= (sbot_pkg::RHS_W'(eaa_s4[i]) + sbot_pkg::RHS_W'(eab_s4[i]))
					<<< sbot_pkg::FRAC_SHIFT;
			end
		end
	end

endmodule

// File: hw/rtl/segment_box_overlap_test.sv
// segment versus axis-aligned box overlap test
//
// the segment (start, direction, fraction) is loaded through the cfg channel,
// register index 0..6 in the order start_x/y/z, dir_x/y/z, seg_fraction;
// cfg.ready is always high; the user must make writes only while no box is
// in flight, which the block itself does not enforce. each item on the box
// channel is one box by its min and max corners; for each box the result
// channel returns one item, overlaps = 1 when no separating axis exists.
// results come out in box order. one box per cycle is sustained while
// result.ready is high: six register stages, the first loaded at the
// accepting edge and the sixth driving result.valid, with all cross product
// partial multipliers working in parallel in stage three.
// reset clears every stage valid bit and loads start = 0, direction = 0,
// fraction = one.
// when result.ready is low the last stage holds; earlier stages keep moving
// into empty slots, and box.ready drops only once all six stages hold items.
module segment_box_overlap_test (
	input logic clk,
	input logic arst_n,
	sbot_cfg_if.sink cfg,
	sbot_box_if.sink box,
	sbot_result_if.source result
);

	sbot_pkg::seg_cfg_t seg;
	sbot_pkg::stage_en_t en;
	sbot_pkg::coord_t lo [3];
	sbot_pkg::coord_t hi [3];
	sbot_pkg::m_t m_s2 [3];
	sbot_pkg::d_t d_s2 [3];
	sbot_pkg::ext_t ext_s2 [3];
	sbot_pkg::a_t absd_s2 [3];
	sbot_pkg::diff_t diff_s5 [3];
	sbot_pkg::rhs_t rhs_s5 [3];
	logic sep_s5;

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic overlaps_s6;
	logic [sbot_pkg::DIFF_W-1:0] absdiff [3];
	logic cross_sep;

	assign lo[0] = box.box_min_x;
	assign lo[1] = box.box_min_y;
	assign lo[2] = box.box_min_z;
	assign hi[0] = box.box_max_x;
	assign hi[1] = box.box_max_y;
	assign hi[2] = box.box_max_z;

	sbot_cfg u_cfg (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg),
		.seg(seg)
	);

	sbot_front u_front (
		.clk(clk),
		.en(en),
		.seg(seg),
		.lo(lo),
		.hi(hi),
		.m_s2(m_s2),
		.d_s2(d_s2),
		.ext_s2(ext_s2),
		.absd_s2(absd_s2)
	);

	sbot_cross u_cross (
		.clk(clk),
		.en(en),
		.m_s2(m_s2),
		.d_s2(d_s2),
		.ext_s2(ext_s2),
		.absd_s2(absd_s2),
		.diff_s5(diff_s5),
		.rhs_s5(rhs_s5),
		.sep_s5(sep_s5)
	);

	// a stage moves when it is empty or the one after it moves
	always_comb begin
		en.s6 = !v_s6 || result.ready;
		en.s5 = !v_s5 || en.s6;
		en.s4 = !v_s4 || en.s5;
		en.s3 = !v_s3 || en.s4;
		en.s2 = !v_s2 || en.s3;
		en.s1 = !v_s1 || en.s2;
	end

	assign box.ready = en.s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			if (en.s1) v_s1 <= box.valid;
			if (en.s2) v_s2 <= v_s1;
			if (en.s3) v_s3 <= v_s2;
			if (en.s4) v_s4 <= v_s3;
			if (en.s5) v_s5 <= v_s4;
			if (en.s6) v_s6 <= v_s5;
		end
	end

	// cross axis compare: |diff| > bound
	always_comb begin
		cross_sep = 1'b0;
		for (int i = 0; i < 3; i++) begin
			absdiff[i] = diff_s5[i][sbot_pkg::DIFF_W-1] ? sbot_pkg::DIFF_W'(-diff_s5[i])
				: sbot_pkg::DIFF_W'(diff_s5[i]);
			cross_sep = cross_sep
				|| ($signed({1'b0, absdiff[i]}) > sbot_pkg::CMP_W'(rhs_s5[i]));
		end
	end

	always_ff @(posedge clk) begin
		if (en.s6) begin
			overlaps_s6 <= !(sep_s5 || cross_sep);
		end
	end

	assign result.valid = v_s6;
	assign result.overlaps = overlaps_s6;

	// input stalls only with every stage full and the output blocked
	a_full_before_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!box.ready |-> (v_s1 && v_s2 && v_s3 && v_s4 && v_s5 && v_s6 && !result.ready))
		else $error("input stalled with a free stage");

	// an item waiting behind a blocked output keeps its data
	a_s5_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s5 && !en.s6) |=> (v_s5 && $stable(sep_s5) && $stable(diff_s5[0])
			&& $stable(rhs_s5[0])))
		else $error("stage five item changed while blocked");

	// a taken result with nothing behind it leaves the output empty
	a_no_repeat: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && result.ready && !v_s5) |=> !result.valid)
		else $error("result item repeated");

endmodule
